FILE: rtl/core/mavg_pkg.sv
// ----------------------------------------------------------------------------
// mavg_pkg: shared definitions for the moving average filter
// Default sizes, the configuration register width and the control group
// that the sequencer hands to the delay line.
// ----------------------------------------------------------------------------
package mavg_pkg;

  localparam int MAVG_MAX_WINDOW   = 64;
  localparam int MAVG_SAMPLE_WIDTH = 16;
  localparam int MAVG_CFG_W        = 7;

  // control of the delay line for one cycle
  typedef struct packed {
    logic push;   // store a sample, fetch the leaving one
    logic clear;  // restart: empty line, pointer back to entry zero
  } mavg_dl_ctl_t;

endpackage

FILE: rtl/core/moving_average_zero_padded_top.sv
// ----------------------------------------------------------------------------
// moving_average_zero_padded_top: causal boxcar moving average
// Keeps a running sum over the last window_length samples (zeros before the
// first ones) and emits sum / window_length, truncated toward zero.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  in_       in   in_valid / in_stall    in_sample  (signed Q8.8)
//  out_      out  out_valid / out_stall  out_average (signed Q8.8)
//  cfg_      in   cfg_wr_en              cfg_wr_data (window_length)
//
//  Input stays stalled from an item's transfer until its result is in the
//  output register; the bit-serial divider produces one quotient bit per
//  cycle over the SUM_W-bit sum.
//  Reset is synchronous, active low; window length returns to one and the
//  delay line reads as empty. A window write also empties it.
//  The result waits in the output register, and input is accepted again
//  once it is there. While a stalled output still holds that register, the
//  divider keeps the finished quotient and the input stays stalled.
// ----------------------------------------------------------------------------
module moving_average_zero_padded_top #(
  parameter int MAX_WINDOW   = mavg_pkg::MAVG_MAX_WINDOW,
  parameter int SAMPLE_WIDTH = mavg_pkg::MAVG_SAMPLE_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]       out_average,
  input  logic                                 cfg_wr_en,
  input  logic [mavg_pkg::MAVG_CFG_W-1:0]      cfg_wr_data
);
  import mavg_pkg::*;

  // sum of MAX_WINDOW samples needs log2(MAX_WINDOW) bits of growth
  localparam int SUM_W = SAMPLE_WIDTH + $clog2(MAX_WINDOW);
  localparam int WIN_W = $clog2(MAX_WINDOW + 1);

  typedef enum logic [2:0] {ST_IDLE, ST_SUM, ST_START, ST_DIV, ST_HOLD} state_t;

  state_t                   state_r;
  logic [SAMPLE_WIDTH-1:0]  sample_r;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic [WIN_W-1:0]         win_r, win_nxt;
  logic                     out_valid_r;
  logic [SAMPLE_WIDTH-1:0]  out_average_r;
  logic                     in_xfer, out_free, out_load;
  mavg_dl_ctl_t             dl_ctl;
  logic [SAMPLE_WIDTH-1:0]  leaving;
  logic                     div_done;
  logic [SAMPLE_WIDTH-1:0]  div_quo;

  assign in_stall    = (state_r != ST_IDLE);
  assign in_xfer     = in_valid && !in_stall;
  assign out_free    = !out_valid_r || !out_stall;
  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;

  // move a finished quotient into the output register
  assign out_load = ((state_r == ST_DIV && div_done) || state_r == ST_HOLD) && out_free;

  // window of zero acts as one; anything above the line depth saturates
  always_comb begin
    if (cfg_wr_data == '0) begin
      win_nxt = WIN_W'(1);
    end else if (32'(cfg_wr_data) > MAX_WINDOW) begin
      win_nxt = WIN_W'(MAX_WINDOW);
    end else begin
      win_nxt = WIN_W'(cfg_wr_data);
    end
  end

  // add the new sample, drop the one leaving the window
  assign sum_nxt = sum_r + SUM_W'($signed(sample_r)) - SUM_W'($signed(leaving));

  assign dl_ctl.push  = in_xfer;
  assign dl_ctl.clear = cfg_wr_en;

  mavg_dline #(
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .WIN_W        (WIN_W)
  ) u_dline (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (dl_ctl),
    .sample  (in_sample),
    .win     (win_r),
    .leaving (leaving)
  );

  mavg_div #(
    .SUM_W        (SUM_W),
    .WIN_W        (WIN_W),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_START),
    .dividend (sum_r),
    .divisor  (win_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // sequencer, running sum, window register and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      win_r       <= WIN_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      // load a new result, or drop the old one once the downstream side takes it
      if (out_load) begin
        out_average_r <= div_quo;
        out_valid_r   <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        win_r <= win_nxt;
        sum_r <= '0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            sample_r <= in_sample;
            state_r  <= ST_SUM;
          end
        end
        ST_SUM: begin
          sum_r   <= sum_nxt;
          state_r <= ST_START;
        end
        ST_START: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          // done lasts one cycle; park the result if the output register is busy
          if (div_done) begin
            state_r <= out_free ? ST_IDLE : ST_HOLD;
          end
        end
        ST_HOLD: begin
          // the divider holds its quotient until the output register frees
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/mavg_dline.sv
// ----------------------------------------------------------------------------
// mavg_dline: circular delay line of the moving average
// Stores each new sample and fetches the sample that leaves the window.
// A fill count stands in for clearing the memory.
// ----------------------------------------------------------------------------
module mavg_dline #(
  parameter int MAX_WINDOW   = mavg_pkg::MAVG_MAX_WINDOW,
  parameter int SAMPLE_WIDTH = mavg_pkg::MAVG_SAMPLE_WIDTH,
  parameter int WIN_W        = $clog2(MAX_WINDOW + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mavg_pkg::mavg_dl_ctl_t     ctl,
  input  logic [SAMPLE_WIDTH-1:0]    sample,
  input  logic [WIN_W-1:0]           win,
  output logic [SAMPLE_WIDTH-1:0]    leaving
);
  import mavg_pkg::*;

  localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int FILL_W = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W  = PTR_W + 2;

  logic [SAMPLE_WIDTH-1:0] mem_r [MAX_WINDOW];
  logic [SAMPLE_WIDTH-1:0] rd_data_r;
  logic                    rd_ok_r;
  logic [PTR_W-1:0]        wp_r, wp_nxt;
  logic [FILL_W-1:0]       fill_r, fill_nxt;
  logic [IDX_W-1:0]        idx_raw, idx_wrap;
  logic [PTR_W-1:0]        old_idx;

  // wp - win, brought back into the ring
  always_comb begin
    idx_raw  = IDX_W'(wp_r) + IDX_W'(MAX_WINDOW) - IDX_W'(win);
    idx_wrap = idx_raw - IDX_W'(MAX_WINDOW);
    old_idx  = (idx_raw >= IDX_W'(MAX_WINDOW)) ? idx_wrap[PTR_W-1:0] : idx_raw[PTR_W-1:0];
  end

  always_comb begin
    wp_nxt   = (wp_r == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_r + PTR_W'(1);
    fill_nxt = (fill_r == FILL_W'(MAX_WINDOW)) ? fill_r : fill_r + FILL_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      wp_r   <= '0;
      fill_r <= '0;
    end else if (ctl.push) begin
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
    end
  end

  // read before write: at a full window the leaving entry is the one under wp
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem_r[wp_r] <= sample;
      rd_data_r   <= mem_r[old_idx];
      rd_ok_r     <= (FILL_W'(win) <= fill_r);
    end
  end

  // an entry not yet written since the last restart reads as zero
  assign leaving = rd_ok_r ? rd_data_r : '0;

endmodule

FILE: rtl/core/mavg_div.sv
// ----------------------------------------------------------------------------
// mavg_div: bit-serial signed divider
// Restoring division of the window sum by the window length, one quotient
// bit per cycle, truncated toward zero.
// ----------------------------------------------------------------------------
module mavg_div #(
  parameter int SUM_W        = 22,
  parameter int WIN_W        = 7,
  parameter int SAMPLE_WIDTH = mavg_pkg::MAVG_SAMPLE_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [SUM_W-1:0]        dividend,
  input  logic [WIN_W-1:0]        divisor,
  output logic                    done,
  output logic [SAMPLE_WIDTH-1:0] quotient
);
  import mavg_pkg::*;

  localparam int CNT_W = $clog2(SUM_W);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

  dstate_t          state_r;
  logic [SUM_W-1:0] mag_r;
  logic [WIN_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             neg_r;
  logic [WIN_W:0]   trial, diff;
  logic             ge;
  logic [SUM_W-1:0] signed_q;

  always_comb begin
    trial   = {rem_r, mag_r[SUM_W-1]};
    diff    = trial - {1'b0, divisor};
    ge      = (trial >= {1'b0, divisor});
    rem_nxt = ge ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      unique case (state_r)
        D_IDLE: begin
          if (start) begin
            mag_r   <= dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
            neg_r   <= dividend[SUM_W-1];
            rem_r   <= '0;
            cnt_r   <= CNT_W'(SUM_W - 1);
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          mag_r <= {mag_r[SUM_W-2:0], ge};
          rem_r <= rem_nxt;
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            state_r <= D_FIN;
          end
        end
        D_FIN: begin
          state_r <= D_IDLE;
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign signed_q = neg_r ? (~mag_r + SUM_W'(1)) : mag_r;
  assign quotient = signed_q[SAMPLE_WIDTH-1:0];
  assign done     = (state_r == D_FIN);

endmodule
